// ----- sv/bspl_pkg.sv -----
// Shared types and constants for the BSP point locator.
`default_nettype none

package bspl_pkg;

	localparam int MAX_NODES_DEF = 4096;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// one stored partition node
	typedef struct packed {
		logic signed [31:0] line_x;
		logic signed [31:0] line_y;
		logic signed [31:0] line_dx;
		logic signed [31:0] line_dy;
		logic [15:0]        front_child;
		logic [15:0]        back_child;
	} node_t;

	typedef struct packed {
		logic               command;
		logic [11:0]        entry_index;
		logic signed [31:0] line_x;
		logic signed [31:0] line_y;
		logic signed [31:0] line_dx;
		logic signed [31:0] line_dy;
		logic [15:0]        front_child;
		logic [15:0]        back_child;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} req_item_t;

	typedef struct packed {
		logic [14:0] leaf_index;
		logic        walk_error;
	} rsp_item_t;

endpackage

`default_nettype wire

// ----- sv/bspl_node_mem.sv -----
// Node table: one write port, one registered read port.
`default_nettype none

module bspl_node_mem
	import bspl_pkg::*;
#(
	parameter int DEPTH = MAX_NODES_DEF,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire node_t         wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output node_t              rdata_q
);

	node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/bspl_side_mul.sv -----
// Shared 16 x 32 signed multiplier with registered product.
`default_nettype none

module bspl_side_mul (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [47:0]      prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 48'(a) * 48'(b);
		end
	end

endmodule

`default_nettype wire

// ----- sv/bsp_point_locate.sv -----
// Top level of the BSP point locator: node table, side-test sequencer, result register.
//
//  channel    | handshake                  | payload     | moves
//  -----------+----------------------------+-------------+---------------------------
//  req        | req_valid / req_ready      | req_item_t  | load or query item
//  rsp        | rsp_valid / rsp_ready      | rsp_item_t  | one item per query
//  node_count | node_count_we (no wait)    | 13 bits     | register write
//
// A load item is written to the node table as it is accepted. A query visits one node per
// pass: check with table read and side test when a special case settles the side, or
// check with table read, first multiply, second multiply, compare when both products are
// needed; a walk error ends at a check. The walk length is set by tree depth. The result
// sits in an output register, so the next item is accepted while it waits; a later
// result holds in the result state until that register is taken. Reset clears control
// state only; the node table holds whatever it held until written.
`default_nettype none

module bsp_point_locate
	import bspl_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        node_count_we,
	input  wire logic [12:0] node_count_wdata,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_item_t   req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_item_t        rsp
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MULR  = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [12:0]        node_count_q;
	logic [14:0]        cur_q;
	logic [12:0]        step_q;
	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] left_q;
	rsp_item_t          res_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic               req_fire;
	logic               is_query;
	logic [16:0]        ent_w;
	logic               mem_we;
	node_t              wr_node;
	node_t              rd_node;
	logic signed [31:0] ex;
	logic signed [31:0] ey;
	logic               fast_hit;
	logic               fast_side;
	logic               cmp_side;
	logic               side;
	logic [15:0]        child;
	logic               check_err;
	logic signed [15:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [47:0] mul_prod;
	logic signed [31:0] right_w;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign is_query  = (req.command == CMD_QUERY);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Loads beyond the table are dropped.
	assign ent_w  = 17'(req.entry_index);
	assign mem_we = req_fire && !is_query && (ent_w < 17'(MAX_NODES));

	assign wr_node.line_x      = req.line_x;
	assign wr_node.line_y      = req.line_y;
	assign wr_node.line_dx     = req.line_dx;
	assign wr_node.line_dy     = req.line_dy;
	assign wr_node.front_child = req.front_child;
	assign wr_node.back_child  = req.back_child;

	bspl_node_mem #(
		.DEPTH (MAX_NODES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (ent_w[AW-1:0]),
		.wdata   (wr_node),
		.re      (state_q == ST_CHECK),
		.raddr   (cur_q[AW-1:0]),
		.rdata_q (rd_node)
	);

	// Offsets of the point from the line origin, wrapping.
	assign ex = px_q - rd_node.line_x;
	assign ey = py_q - rd_node.line_y;

	// Axis-aligned lines and the sign shortcut settle the side without products.
	always_comb begin
		fast_hit  = 1'b1;
		fast_side = 1'b0;
		if (rd_node.line_dx == 32'sd0) begin
			fast_side = (px_q <= rd_node.line_x) ? (rd_node.line_dy > 32'sd0)
			                                     : (rd_node.line_dy < 32'sd0);
		end else if (rd_node.line_dy == 32'sd0) begin
			fast_side = (py_q <= rd_node.line_y) ? (rd_node.line_dx < 32'sd0)
			                                     : (rd_node.line_dx > 32'sd0);
		end else if (rd_node.line_dy[31] ^ rd_node.line_dx[31] ^ ex[31] ^ ey[31]) begin
			fast_side = rd_node.line_dy[31] ^ ex[31];
		end else begin
			fast_hit = 1'b0;
		end
	end

	// First pass: integer part of dy times ex; second pass: ey times integer part of dx.
	always_comb begin
		if (state_q == ST_READ) begin
			mul_a = rd_node.line_dy[31:16];
			mul_b = ex;
		end else begin
			mul_a = rd_node.line_dx[31:16];
			mul_b = ey;
		end
	end

	bspl_side_mul u_mul (
		.clk    (clk),
		.en     ((state_q == ST_READ) || (state_q == ST_MULR)),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (mul_prod)
	);

	assign right_w  = mul_prod[47:16];
	assign cmp_side = !(right_w < left_q);
	assign side     = (state_q == ST_CMP) ? cmp_side : fast_side;
	assign child    = side ? rd_node.back_child : rd_node.front_child;

	assign check_err = (16'(cur_q) >= 16'(node_count_q)) ||
	                   (16'(cur_q) >= 16'(MAX_NODES)) ||
	                   (step_q >= node_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (node_count_we) begin
			node_count_q <= node_count_wdata;
		end
	end

	// Sequencer: one node per pass through check, read, and optionally two multiplies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Present a finished result, or drop valid once the item is taken.
			if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && is_query) begin
						step_q <= '0;
						if (node_count_q == 13'd0) begin
							cur_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							cur_q   <= 15'(node_count_q - 13'd1);
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					state_q <= check_err ? ST_DONE : ST_READ;
				end
				ST_READ: begin
					if (fast_hit) begin
						step_q <= step_q + 13'd1;
						if (child[15]) begin
							state_q <= ST_DONE;
						end else begin
							cur_q   <= child[14:0];
							state_q <= ST_CHECK;
						end
					end else begin
						state_q <= ST_MULR;
					end
				end
				ST_MULR: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					step_q <= step_q + 13'd1;
					if (child[15]) begin
						state_q <= ST_DONE;
					end else begin
						cur_q   <= child[14:0];
						state_q <= ST_CHECK;
					end
				end
				ST_DONE: begin
					// Hold the result until the output register is free.
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire && is_query) begin
			px_q  <= req.point_x;
			py_q  <= req.point_y;
			res_q <= '0;
		end
		if (state_q == ST_MULR) begin
			left_q <= mul_prod[47:16];
		end
		if ((state_q == ST_CHECK) && check_err) begin
			res_q.leaf_index <= '0;
			res_q.walk_error <= 1'b1;
		end
		if (((state_q == ST_READ) && fast_hit) || (state_q == ST_CMP)) begin
			res_q.leaf_index <= child[14:0];
			res_q.walk_error <= 1'b0;
		end
		if ((state_q == ST_DONE) && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

	// An error result never carries a leaf.
	a_err_no_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.walk_error |-> rsp.leaf_index == 15'd0)
		else $error("walk error with nonzero leaf");

	// A query holds the block busy on the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && is_query |=> !req_ready)
		else $error("ready during query walk");

	// The walk never visits more nodes than the table holds.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> step_q < node_count_q)
		else $error("walk step beyond node count");

	// Leaving the result state always loads the output register.
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && (!rsp_valid_q || rsp_ready) |=> rsp_valid_q)
		else $error("result not presented");

endmodule

`default_nettype wire
